// File: sv/htd_pkg.sv
// Shared types and constants of the Huffman tree decoder.
package htd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned VBITS_W = 4;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_BYTE  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADLEN  = 2'd3
  } status_e;

  // Control sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_BAD,
    S_LOAD_STEP,
    S_LOAD_BLANK,
    S_LOAD_WAIT,
    S_BYTE_FETCH,
    S_BYTE_BIT,
    S_BYTE_CHILD,
    S_FLUSH
  } state_e;

  // Request from the sequencer to the result buffer
  typedef struct packed {
    logic             push;   // new result into the holding slot
    logic             flush;  // end of transaction: release held result as last
    logic [SYM_W-1:0] sym;
    status_e          st;
  } res_req_t;

endpackage

// File: sv/htd_in_if.sv
// Input channel of the Huffman tree decoder.
interface htd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] entry_symbol;
  logic [31:0] entry_code;
  logic [5:0] entry_length;
  logic [7:0] coded_byte;
  logic [3:0] valid_bits;

  modport source (
    output valid, req_type, entry_symbol, entry_code, entry_length, coded_byte, valid_bits,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_symbol, entry_code, entry_length, coded_byte, valid_bits,
    output ready
  );
endinterface

// File: sv/htd_out_if.sv
// Result channel of the Huffman tree decoder.
interface htd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_out;
  logic [1:0] status;
  logic       last;

  modport source (
    output valid, symbol_out, status, last,
    input  ready
  );
  modport sink (
    input  valid, symbol_out, status, last,
    output ready
  );
endinterface

// File: sv/htd_node_mem.sv
// Node memory: one write port, one read port with registered read data.
module htd_node_mem
  import htd_pkg::*;
#(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 28
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data valid the cycle after the address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/htd_result_buf.sv
// Result buffer: holding slot that resolves the last flag, then the output register.
module htd_result_buf
  import htd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  res_req_t     req_i,
  output logic         blocked_o,
  htd_out_if.source    out_o
);

  logic             pend_q, pend_d;
  logic [SYM_W-1:0] pend_sym_q, pend_sym_d;
  status_e          pend_st_q, pend_st_d;
  logic             out_valid_q, out_valid_d;
  logic [SYM_W-1:0] out_sym_q, out_sym_d;
  status_e          out_st_q, out_st_d;
  logic             out_last_q, out_last_d;
  logic             out_free;

  assign out_free  = !out_valid_q || out_o.ready;
  assign blocked_o = pend_q && !out_free;

  // A held result moves out when the next one arrives (not last) or on flush (last)
  always_comb begin
    pend_d      = pend_q;
    pend_sym_d  = pend_sym_q;
    pend_st_d   = pend_st_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_sym_d   = out_sym_q;
    out_st_d    = out_st_q;
    out_last_d  = out_last_q;
    if (!blocked_o) begin
      if (req_i.push) begin
        if (pend_q) begin
          out_valid_d = 1'b1;
          out_sym_d   = pend_sym_q;
          out_st_d    = pend_st_q;
          out_last_d  = 1'b0;
        end
        pend_d     = 1'b1;
        pend_sym_d = req_i.sym;
        pend_st_d  = req_i.st;
      end else if (req_i.flush && pend_q) begin
        out_valid_d = 1'b1;
        out_sym_d   = pend_sym_q;
        out_st_d    = pend_st_q;
        out_last_d  = 1'b1;
        pend_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sym_q <= pend_sym_d;
    pend_st_q  <= pend_st_d;
    out_sym_q  <= out_sym_d;
    out_st_q   <= out_st_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.symbol_out = out_sym_q;
  assign out_o.status     = 2'(out_st_q);
  assign out_o.last       = out_last_q;

endmodule

// File: sv/huffman_tree_decoder.sv
// Huffman decoder: code tree in a node memory, walked one code bit at a time.
//
// in_i carries one transaction per item: clear tree, load one code entry, or a coded
// byte. out_o returns results (symbol_out, status, last); last marks the final result
// of an item. A clear returns nothing; a load returns exactly one result.
// Items are taken one at a time: in_i.ready is high only while the sequencer is idle.
// Load: each code bit whose node exists costs a node read (registered read data),
// and each newly allocated node costs a link into its parent and a blank node write.
// Coded byte: each walked bit reads its child node (a missing child needs no read),
// plus a node fetch when the walk resumes inside the tree; the item is accepted in
// the idle state and closed by a flush. The node memory has one write port and one
// registered read port, and the sequencer makes one access per step.
// Each result waits in a slot until the next result of its item or the end of the
// item, so that the last flag can be set; it then moves to the output register.
// Reset: the root node is held in flip-flops and cleared at once; other nodes are
// written when allocated, so no clearing pass is needed and in_i.ready rises right
// after reset. The walk position survives between coded bytes.
// When out_o stalls, one result is held in the output register and one in the slot;
// the sequencer waits on the next result until space frees up.
module huffman_tree_decoder
  import htd_pkg::*;
#(
  parameter int unsigned NODE_COUNT   = 512,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htd_in_if.sink     in_i,
  htd_out_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(NODE_COUNT);
  localparam int unsigned CntW = $clog2(NODE_COUNT + 1);
  localparam int unsigned PosW = $clog2(MAX_CODE_LEN + 1);

  typedef struct packed {
    logic [1:0][IdxW-1:0] child;
    logic [1:0]           has;
    logic [SYM_W-1:0]     sym;
  } node_t;

  localparam int unsigned NodeW = $bits(node_t);

  state_e             state_q, state_d;
  node_t              root_q, root_d;
  node_t              node_q, node_d;
  logic [IdxW-1:0]    walk_q, walk_d;
  logic [CntW-1:0]    used_q, used_d;
  logic [IdxW-1:0]    cur_q, cur_d;
  logic [IdxW-1:0]    child_q, child_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic [VBITS_W-1:0] cnt_q, cnt_d;

  logic              mem_wr_en;
  logic [IdxW-1:0]   mem_wr_addr;
  node_t             mem_wr_data;
  logic              mem_rd_en;
  logic [IdxW-1:0]   mem_rd_addr;
  logic [NodeW-1:0]  mem_rd_raw;
  node_t             mem_rd;

  res_req_t          res;
  logic              blocked;

  logic [PosW-1:0]   bit_idx;
  logic [CODE_W-1:0] code_sh;
  logic              code_bit;
  logic              walk_bit;
  logic              cur_bit;
  logic              len_bad;
  logic [IdxW-1:0]   new_idx;
  node_t             upd;

  htd_node_mem #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NodeW)
  ) u_node_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_raw)
  );

  assign mem_rd = node_t'(mem_rd_raw);

  htd_result_buf u_result_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (res),
    .blocked_o (blocked),
    .out_o     (out_o)
  );

  // Code bit at position pos-1; bits above the 32-bit field read as zero
  assign bit_idx  = pos_q - PosW'(1);
  assign code_sh  = code_q >> bit_idx;
  assign code_bit = code_sh[0];
  // Coded byte shifts out MSB first
  assign walk_bit = byte_q[BYTE_W-1];
  assign cur_bit  = (state_q == S_BYTE_BIT) ? walk_bit : code_bit;

  assign len_bad = (in_i.entry_length == '0) ||
                   ({1'b0, in_i.entry_length} > 7'(MAX_CODE_LEN));
  assign new_idx = used_q[IdxW-1:0];

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer: next state, memory accesses, result requests
  always_comb begin
    state_d     = state_q;
    root_d      = root_q;
    node_d      = node_q;
    walk_d      = walk_q;
    used_d      = used_q;
    cur_d       = cur_q;
    child_d     = child_q;
    pos_d       = pos_q;
    code_d      = code_q;
    sym_d       = sym_q;
    byte_d      = byte_q;
    cnt_d       = cnt_q;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cur_q;
    mem_wr_data = node_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = node_q.child[cur_bit];
    res         = '0;
    res.st      = ST_OK;
    upd         = node_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (req_e'(in_i.req_type))
            REQ_CLEAR: begin
              root_d = '0;
              used_d = CntW'(1);
              walk_d = '0;
            end
            REQ_LOAD: begin
              sym_d  = in_i.entry_symbol;
              code_d = in_i.entry_code;
              pos_d  = PosW'(in_i.entry_length);
              node_d = root_q;
              cur_d  = '0;
              state_d = len_bad ? S_LOAD_BAD : S_LOAD_STEP;
            end
            REQ_BYTE: begin
              byte_d = in_i.coded_byte;
              cnt_d  = (in_i.valid_bits > VBITS_W'(BYTE_W)) ? VBITS_W'(BYTE_W)
                                                            : in_i.valid_bits;
              if (walk_q == '0) begin
                node_d  = root_q;
                state_d = S_BYTE_BIT;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = walk_q;
                state_d     = S_BYTE_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_LOAD_BAD: begin
        if (!blocked) begin
          res.push = 1'b1;
          res.st   = ST_BADLEN;
          walk_d   = '0;
          state_d  = S_FLUSH;
        end
      end

      S_LOAD_STEP: begin
        if (pos_q == '0) begin
          // End of path: this node takes the symbol
          if (!blocked) begin
            upd.sym = sym_q;
            if (cur_q == '0) begin
              root_d = upd;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_data = upd;
            end
            res.push = 1'b1;
            state_d  = S_FLUSH;
          end
        end else if (node_q.has[code_bit]) begin
          // Follow an existing child
          mem_rd_en = 1'b1;
          cur_d     = node_q.child[code_bit];
          pos_d     = pos_q - PosW'(1);
          state_d   = S_LOAD_WAIT;
        end else if (used_q == CntW'(NODE_COUNT)) begin
          if (!blocked) begin
            res.push = 1'b1;
            res.st   = ST_FULL;
            walk_d   = '0;
            state_d  = S_FLUSH;
          end
        end else begin
          // Allocate: link the new node into its parent
          upd.has[code_bit]   = 1'b1;
          upd.child[code_bit] = new_idx;
          if (cur_q == '0) begin
            root_d = upd;
          end else begin
            mem_wr_en   = 1'b1;
            mem_wr_data = upd;
          end
          cur_d   = new_idx;
          used_d  = used_q + CntW'(1);
          node_d  = '0;
          pos_d   = pos_q - PosW'(1);
          state_d = S_LOAD_BLANK;
        end
      end

      S_LOAD_BLANK: begin
        // New node starts childless
        mem_wr_en   = 1'b1;
        mem_wr_data = '0;
        state_d     = S_LOAD_STEP;
      end

      S_LOAD_WAIT: begin
        node_d  = mem_rd;
        state_d = S_LOAD_STEP;
      end

      S_BYTE_FETCH: begin
        node_d  = mem_rd;
        state_d = S_BYTE_BIT;
      end

      S_BYTE_BIT: begin
        if (cnt_q == '0) begin
          state_d = S_FLUSH;
        end else if (!node_q.has[walk_bit]) begin
          // Missing child: report and restart from the root
          if (!blocked) begin
            res.push = 1'b1;
            res.st   = ST_MISSING;
            walk_d   = '0;
            node_d   = root_q;
            byte_d   = byte_q << 1;
            cnt_d    = cnt_q - VBITS_W'(1);
          end
        end else begin
          mem_rd_en = 1'b1;
          child_d   = node_q.child[walk_bit];
          state_d   = S_BYTE_CHILD;
        end
      end

      S_BYTE_CHILD: begin
        if (mem_rd.has == 2'b00) begin
          // Leaf: emit its symbol, back to the root
          if (!blocked) begin
            res.push = 1'b1;
            res.sym  = mem_rd.sym;
            walk_d   = '0;
            node_d   = root_q;
            byte_d   = byte_q << 1;
            cnt_d    = cnt_q - VBITS_W'(1);
            state_d  = S_BYTE_BIT;
          end
        end else begin
          walk_d  = child_q;
          node_d  = mem_rd;
          byte_d  = byte_q << 1;
          cnt_d   = cnt_q - VBITS_W'(1);
          state_d = S_BYTE_BIT;
        end
      end

      S_FLUSH: begin
        if (!blocked) begin
          res.flush = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      root_q  <= '0;
      walk_q  <= '0;
      used_q  <= CntW'(1);
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      root_q  <= root_d;
      walk_q  <= walk_d;
      used_q  <= used_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    cur_q   <= cur_d;
    child_q <= child_d;
    code_q  <= code_d;
    sym_q   <= sym_d;
    byte_q  <= byte_d;
  end

  // Fill count stays within the store and never drops below the root
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q >= CntW'(1)) && (used_q <= CntW'(NODE_COUNT)))
    else $error("node fill count out of range");

  // Walk position always names an allocated node
  a_walk_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, walk_q} < (IdxW + 1)'(used_q))
    else $error("walk position beyond allocated nodes");

  // A clear leaves an empty tree and the walk at the root
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.req_type == REQ_CLEAR)) |=>
    ((root_q.has == 2'b00) && (used_q == CntW'(1)) && (walk_q == '0)))
    else $error("tree not empty after clear");

endmodule
